// ===== rtl/damped_feedback_delay_top_defines.svh =====
// Assertion macros used by the top-level RTL file.
// Both sample on clk and are disabled while arst_n is low.
`ifndef DAMPED_FEEDBACK_DELAY_TOP_DEFINES_SVH
`define DAMPED_FEEDBACK_DELAY_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DFD_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define DFD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/dfd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package dfd_pkg;

	localparam int DELAY_DEPTH = 4096;
	localparam int CHANNELS    = 2;

	localparam int IDX_W       = $clog2(DELAY_DEPTH);
	localparam int CH_W        = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int STORE_DEPTH = CHANNELS * DELAY_DEPTH;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);

	localparam int SAMPLE_W = 24;
	localparam int COEF_W   = 24;
	localparam int GAIN_W   = 17;
	localparam int DLY_W    = 12;
	localparam int MEM_W    = 40;
	localparam int CFG_W    = 24;
	localparam int CFG_IDX_W = 3;

	// shared multiplier: coefficient or gain on one side, sample on the other
	localparam int MUL_A_W = COEF_W + 1;
	localparam int MUL_B_W = SAMPLE_W;
	localparam int PROD_W  = MUL_A_W + MUL_B_W;
	localparam int ACC_W   = 52;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_FEEDBACK_GAIN = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DELAY_SAMPLES = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_B0       = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_B1       = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_B2       = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_A1       = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_A2       = 3'd6;

	localparam logic signed [ACC_W-1:0] S24_MAX = (ACC_W'(1) <<< (SAMPLE_W - 1)) - ACC_W'(1);
	localparam logic signed [ACC_W-1:0] S24_MIN = ~S24_MAX;
	localparam logic signed [ACC_W-1:0] S40_MAX = (ACC_W'(1) <<< (MEM_W - 1)) - ACC_W'(1);
	localparam logic signed [ACC_W-1:0] S40_MIN = ~S40_MAX;

	typedef struct packed {
		logic signed [GAIN_W-1:0] feedback_gain;
		logic [DLY_W-1:0]         delay_samples;
		logic signed [COEF_W-1:0] coef_b0;
		logic signed [COEF_W-1:0] coef_b1;
		logic signed [COEF_W-1:0] coef_b2;
		logic signed [COEF_W-1:0] coef_a1;
		logic signed [COEF_W-1:0] coef_a2;
	} cfg_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_MUL_B0,
		ST_Y,
		ST_M1_ACC,
		ST_M1_DONE,
		ST_M2_ACC,
		ST_M2_DONE,
		ST_STORE
	} state_t;

	// round to nearest, halves up, then drop s bits
	function automatic logic signed [ACC_W-1:0] rnd_shift(
		input logic signed [ACC_W-1:0] v,
		input int unsigned s
	);
		logic signed [ACC_W-1:0] t;
		t = v + (ACC_W'(1) <<< (s - 1));
		return t >>> s;
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] sat24(input logic signed [ACC_W-1:0] v);
		logic signed [ACC_W-1:0] c;
		if (v > S24_MAX) begin
			c = S24_MAX;
		end else if (v < S24_MIN) begin
			c = S24_MIN;
		end else begin
			c = v;
		end
		return c[SAMPLE_W-1:0];
	endfunction

	function automatic logic signed [MEM_W-1:0] sat40(input logic signed [ACC_W-1:0] v);
		logic signed [ACC_W-1:0] c;
		if (v > S40_MAX) begin
			c = S40_MAX;
		end else if (v < S40_MIN) begin
			c = S40_MIN;
		end else begin
			c = v;
		end
		return c[MEM_W-1:0];
	endfunction

endpackage

`default_nettype wire

// ===== rtl/dfd_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dfd_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 8192
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]              rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// ===== rtl/dfd_mul.sv =====
`timescale 1ns / 1ps
`default_nettype none

// shared signed multiplier, product registered
module dfd_mul (
	input  wire logic                                clk,
	input  wire logic                                en,
	input  wire logic signed [dfd_pkg::MUL_A_W-1:0]  a,
	input  wire logic signed [dfd_pkg::MUL_B_W-1:0]  b,
	output logic signed [dfd_pkg::PROD_W-1:0]        prod_q
);

	always_ff @(posedge clk) begin
		if (en) begin
			prod_q <= dfd_pkg::PROD_W'(a) * dfd_pkg::PROD_W'(b);
		end
	end

endmodule

`default_nettype wire

// ===== rtl/dfd_cfg.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dfd_cfg (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            we,
	input  wire logic [dfd_pkg::CFG_IDX_W-1:0]   index,
	input  wire logic [dfd_pkg::CFG_W-1:0]       data,
	output dfd_pkg::cfg_t                        cfg_q
);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.feedback_gain <= 17'sd8192;
			cfg_q.delay_samples <= 12'd480;
			cfg_q.coef_b0       <= 24'sd4194304;
			cfg_q.coef_b1       <= '0;
			cfg_q.coef_b2       <= '0;
			cfg_q.coef_a1       <= '0;
			cfg_q.coef_a2       <= '0;
		end else if (we) begin
			case (index)
				dfd_pkg::REG_FEEDBACK_GAIN: cfg_q.feedback_gain <= data[dfd_pkg::GAIN_W-1:0];
				dfd_pkg::REG_DELAY_SAMPLES: cfg_q.delay_samples <= data[dfd_pkg::DLY_W-1:0];
				dfd_pkg::REG_COEF_B0:       cfg_q.coef_b0       <= data[dfd_pkg::COEF_W-1:0];
				dfd_pkg::REG_COEF_B1:       cfg_q.coef_b1       <= data[dfd_pkg::COEF_W-1:0];
				dfd_pkg::REG_COEF_B2:       cfg_q.coef_b2       <= data[dfd_pkg::COEF_W-1:0];
				dfd_pkg::REG_COEF_A1:       cfg_q.coef_a1       <= data[dfd_pkg::COEF_W-1:0];
				dfd_pkg::REG_COEF_A2:       cfg_q.coef_a2       <= data[dfd_pkg::COEF_W-1:0];
				default: ;  // unused index, write dropped
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== rtl/damped_feedback_delay_top.sv =====
// An accepted word runs through READ, MUL_B0, Y, M1_ACC, M1_DONE, M2_ACC, M2_DONE and STORE,
// where its result word is registered; one idle step and eight sequencer steps per word, and no
// new word is taken until the last is stored. The shared multiplier does six products per word.
// The store step waits while a result word stalls. Reset: arst_n clears control, write indexes
// and filter memories at once, then a clearing pass zeroes the delay store, taking no input word.
// Configuration writes are taken during the clearing pass as at any other time.
`timescale 1ns / 1ps
`default_nettype none

`include "damped_feedback_delay_top_defines.svh"

module damped_feedback_delay_top (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	// configuration write port
	input  wire logic                                  cfg_we,
	input  wire logic [dfd_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  wire logic [dfd_pkg::CFG_W-1:0]             cfg_data,
	// input words
	input  wire logic                                  in_valid,
	output logic                                       in_ready,
	input  wire logic                                  channel,
	input  wire logic signed [dfd_pkg::SAMPLE_W-1:0]   sample_in,
	// result words
	output logic                                       out_valid,
	input  wire logic                                  out_ready,
	output logic                                       channel_out,
	output logic signed [dfd_pkg::SAMPLE_W-1:0]        sample_out
);

	localparam int IDX_W  = dfd_pkg::IDX_W;
	localparam int CH_W   = dfd_pkg::CH_W;
	localparam int ADDR_W = dfd_pkg::ADDR_W;
	localparam int ACC_W  = dfd_pkg::ACC_W;
	localparam int SW     = dfd_pkg::SAMPLE_W;
	localparam int MW     = dfd_pkg::MEM_W;

	dfd_pkg::cfg_t   cfg;
	dfd_pkg::state_t state_q, state_d;

	// control state
	logic [ADDR_W-1:0]           clr_q;
	logic [IDX_W-1:0]            wi_q  [dfd_pkg::CHANNELS];
	logic signed [MW-1:0]        fm1_q [dfd_pkg::CHANNELS];
	logic signed [MW-1:0]        fm2_q [dfd_pkg::CHANNELS];
	logic                        out_valid_q;

	// per-word payload
	logic [CH_W-1:0]             ch_q;
	logic                        chan_q;
	logic signed [SW-1:0]        x_q;
	logic signed [SW-1:0]        d_q;
	logic signed [SW-1:0]        y_q;
	logic signed [ACC_W-1:0]     acc_q;
	logic                        chan_out_q;
	logic signed [SW-1:0]        sample_out_q;

	// datapath
	logic                                  mul_en;
	logic signed [dfd_pkg::MUL_A_W-1:0]    mul_a;
	logic signed [dfd_pkg::MUL_B_W-1:0]    mul_b;
	logic signed [dfd_pkg::PROD_W-1:0]     prod_q;
	logic signed [ACC_W-1:0]               prod_ext;
	logic signed [ACC_W-1:0]               add_a, add_b, sum;
	logic signed [SW-1:0]                  y_next, st_next, o_next;
	logic signed [MW-1:0]                  m_next;

	// store access
	logic                 ram_we;
	logic [ADDR_W-1:0]    ram_waddr, ram_raddr;
	logic [SW-1:0]        ram_wdata, ram_rdata;
	logic [IDX_W-1:0]     wi_cur, dly_c, rd_idx, wi_inc;
	logic                 out_load;

	dfd_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (cfg_we),
		.index  (cfg_index),
		.data   (cfg_data),
		.cfg_q  (cfg)
	);

	dfd_mul u_mul (
		.clk    (clk),
		.en     (mul_en),
		.a      (mul_a),
		.b      (mul_b),
		.prod_q (prod_q)
	);

	dfd_ram #(
		.WIDTH (SW),
		.DEPTH (dfd_pkg::STORE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// read index: delay clamped below depth, wraps around the channel's ring
	always_comb begin
		wi_cur = wi_q[ch_q];
		if (32'(cfg.delay_samples) > dfd_pkg::DELAY_DEPTH - 1) begin
			dly_c = IDX_W'(dfd_pkg::DELAY_DEPTH - 1);
		end else begin
			dly_c = IDX_W'(cfg.delay_samples);
		end
		if (wi_cur >= dly_c) begin
			rd_idx = wi_cur - dly_c;
		end else begin
			rd_idx = IDX_W'((IDX_W + 1)'(wi_cur) + (IDX_W + 1)'(dfd_pkg::DELAY_DEPTH)
				- (IDX_W + 1)'(dly_c));
		end
		if (32'(wi_cur) == dfd_pkg::DELAY_DEPTH - 1) begin
			wi_inc = '0;
		end else begin
			wi_inc = wi_cur + IDX_W'(1);
		end
		ram_raddr = {ch_q, rd_idx};
	end

	// shared adder with rounding and saturation taps for each use; the output sum x + y has its own adder
	assign prod_ext = ACC_W'(prod_q);
	assign sum      = add_a + add_b;
	assign y_next   = dfd_pkg::sat24(dfd_pkg::rnd_shift(sum, 22));
	assign m_next   = dfd_pkg::sat40(dfd_pkg::rnd_shift(sum, 9));
	assign st_next  = dfd_pkg::sat24(dfd_pkg::rnd_shift(sum, 14));
	assign o_next   = dfd_pkg::sat24(ACC_W'(x_q) + ACC_W'(y_q));

	// sequencer: next state, input ready, multiplier operands, adder operands, store writes, output load
	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		mul_en    = 1'b0;
		mul_a     = '0;
		mul_b     = '0;
		add_a     = '0;
		add_b     = '0;
		ram_we    = 1'b0;
		ram_waddr = clr_q;
		ram_wdata = '0;
		out_load  = 1'b0;
		case (state_q)
			dfd_pkg::ST_CLEAR: begin
				ram_we = 1'b1;
				if (32'(clr_q) == dfd_pkg::STORE_DEPTH - 1) begin
					state_d = dfd_pkg::ST_IDLE;
				end
			end
			dfd_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = dfd_pkg::ST_READ;
				end
			end
			dfd_pkg::ST_READ: begin
				// store read issued here, data lands next cycle
				state_d = dfd_pkg::ST_MUL_B0;
			end
			dfd_pkg::ST_MUL_B0: begin
				mul_en  = 1'b1;
				mul_a   = dfd_pkg::MUL_A_W'(cfg.coef_b0);
				mul_b   = ram_rdata;
				state_d = dfd_pkg::ST_Y;
			end
			dfd_pkg::ST_Y: begin
				// y = b0*d + m1
				add_a   = prod_ext;
				add_b   = ACC_W'(fm1_q[ch_q]) <<< 9;
				mul_en  = 1'b1;
				mul_a   = dfd_pkg::MUL_A_W'(cfg.coef_b1);
				mul_b   = d_q;
				state_d = dfd_pkg::ST_M1_ACC;
			end
			dfd_pkg::ST_M1_ACC: begin
				add_a   = prod_ext;
				add_b   = ACC_W'(fm2_q[ch_q]) <<< 9;
				mul_en  = 1'b1;
				mul_a   = dfd_pkg::MUL_A_W'(cfg.coef_a1);
				mul_b   = y_q;
				state_d = dfd_pkg::ST_M1_DONE;
			end
			dfd_pkg::ST_M1_DONE: begin
				// m1 = b1*d + m2 - a1*y
				add_a   = acc_q;
				add_b   = -prod_ext;
				mul_en  = 1'b1;
				mul_a   = dfd_pkg::MUL_A_W'(cfg.coef_b2);
				mul_b   = d_q;
				state_d = dfd_pkg::ST_M2_ACC;
			end
			dfd_pkg::ST_M2_ACC: begin
				add_a   = prod_ext;
				mul_en  = 1'b1;
				mul_a   = dfd_pkg::MUL_A_W'(cfg.coef_a2);
				mul_b   = y_q;
				state_d = dfd_pkg::ST_M2_DONE;
			end
			dfd_pkg::ST_M2_DONE: begin
				// m2 = b2*d - a2*y
				add_a   = acc_q;
				add_b   = -prod_ext;
				mul_en  = 1'b1;
				mul_a   = dfd_pkg::MUL_A_W'(cfg.feedback_gain);
				mul_b   = y_q;
				state_d = dfd_pkg::ST_STORE;
			end
			dfd_pkg::ST_STORE: begin
				// store = x + gain*y; waits here while the output word is stalled
				add_a = ACC_W'(x_q) <<< 14;
				add_b = prod_ext;
				if (!out_valid_q || out_ready) begin
					ram_we    = 1'b1;
					ram_waddr = {ch_q, wi_cur};
					ram_wdata = st_next;
					out_load  = 1'b1;
					state_d   = dfd_pkg::ST_IDLE;
				end
			end
			default: state_d = dfd_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= dfd_pkg::ST_CLEAR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < dfd_pkg::CHANNELS; i++) begin
				wi_q[i]  <= '0;
				fm1_q[i] <= '0;
				fm2_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (state_q == dfd_pkg::ST_CLEAR) begin
				clr_q <= clr_q + ADDR_W'(1);
			end
			if (state_q == dfd_pkg::ST_M1_DONE) begin
				fm1_q[ch_q] <= m_next;
			end
			if (state_q == dfd_pkg::ST_M2_DONE) begin
				fm2_q[ch_q] <= m_next;
			end
			if (out_load) begin
				wi_q[ch_q]  <= wi_inc;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			ch_q   <= CH_W'(32'(channel) % dfd_pkg::CHANNELS);
			chan_q <= channel;
			x_q    <= sample_in;
		end
		if (state_q == dfd_pkg::ST_MUL_B0) begin
			d_q <= ram_rdata;
		end
		if (state_q == dfd_pkg::ST_Y) begin
			y_q <= y_next;
		end
		if (state_q == dfd_pkg::ST_M1_ACC || state_q == dfd_pkg::ST_M2_ACC) begin
			acc_q <= sum;
		end
		if (out_load) begin
			chan_out_q   <= chan_q;
			sample_out_q <= o_next;
		end
	end

	assign out_valid   = out_valid_q;
	assign channel_out = chan_out_q;
	assign sample_out  = sample_out_q;

	`DFD_ASSERT_NOW(a_out_from_store, $rose(out_valid), $past(state_q == dfd_pkg::ST_STORE), "result word not launched from the store step")
	`DFD_ASSERT_NOW(a_ram_we_phase, ram_we, (state_q == dfd_pkg::ST_CLEAR) || (state_q == dfd_pkg::ST_STORE), "store written outside clear or store step")
	`DFD_ASSERT_NEXT(a_accept_reads, in_valid && in_ready, state_q == dfd_pkg::ST_READ, "accepted word did not start a store read")
	`DFD_ASSERT_NEXT(a_store_holds, (state_q == dfd_pkg::ST_STORE) && out_valid && !out_ready, state_q == dfd_pkg::ST_STORE, "store step left while output word stalled")

endmodule

`default_nettype wire
